/* hdl/spi_dma_controller_registers_defines.svh */
// Assertion macros used by the checker of the SPI DMA controller register block.
`ifndef SPI_DMA_CONTROLLER_REGISTERS_DEFINES_SVH
`define SPI_DMA_CONTROLLER_REGISTERS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SDCR_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SDCR_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/sdcr_pkg.sv */
// Package with the register map, masks, reset values and beat types of the register block.
`timescale 1ns / 1ps
package sdcr_pkg;

  localparam int TargetCount = 4;
  localparam int MaxTransfer = 65536;
  localparam int RegCount    = 20;
  localparam int LenW        = 17;
  localparam int AddrW       = 36;
  localparam int IdxW        = 5;

  localparam logic [IdxW-1:0] IxCtrl        = 5'd0;
  localparam logic [IdxW-1:0] IxModes       = 5'd1;
  localparam logic [IdxW-1:0] IxConfig      = 5'd2;
  localparam logic [IdxW-1:0] IxStatus      = 5'd3;
  localparam logic [IdxW-1:0] IxCpuConfig   = 5'd4;
  localparam logic [IdxW-1:0] IxTimings     = 5'd5;
  localparam logic [IdxW-1:0] IxIrqEnable   = 5'd6;
  localparam logic [IdxW-1:0] IxDma         = 5'd7;
  localparam logic [IdxW-1:0] IxInstrModes  = 5'd8;
  localparam logic [IdxW-1:0] IxInstrCs     = 5'd9;
  localparam logic [IdxW-1:0] IxInstrLen    = 5'd10;
  localparam logic [IdxW-1:0] IxInstrParams = 5'd11;
  localparam logic [IdxW-1:0] IxTxLo        = 5'd12;
  localparam logic [IdxW-1:0] IxTxHi        = 5'd13;
  localparam logic [IdxW-1:0] IxRxLo        = 5'd14;
  localparam logic [IdxW-1:0] IxRxHi        = 5'd15;
  localparam logic [IdxW-1:0] IxAxiId       = 5'd16;
  localparam logic [IdxW-1:0] IxVersion     = 5'd18;
  localparam logic [IdxW-1:0] IxCpuTimings  = 5'd19;

  localparam int UnlockBit   = 15;
  localparam int DmaGoBit    = 31;
  localparam int StDoneBit   = 16;
  localparam int StFinishBit = 17;
  localparam int HoldBit     = 0;
  localparam int DoneBit     = 1;
  localparam int SendBit     = 2;
  localparam int RecvBit     = 3;

  typedef struct packed {
    logic        known;
    logic [31:0] rd;
    logic [31:0] wr;
    logic [31:0] lock;
    logic [31:0] clr;
  } masks_t;

  typedef struct packed {
    logic        valid;
    logic        is_write;
    logic [7:0]  offset;
    logic [31:0] wdata;
  } access_t;

  typedef struct packed {
    logic [31:0]      read_data;
    logic             irq_level;
    logic [3:0]       chip_select_lines;
    logic             xfer_start;
    logic             xfer_send;
    logic             xfer_receive;
    logic [LenW-1:0]  xfer_length;
    logic [AddrW-1:0] xfer_source_addr;
    logic [AddrW-1:0] xfer_dest_addr;
    logic [1:0]       xfer_target;
  } result_t;

  function automatic masks_t reg_masks(logic [IdxW-1:0] idx);
    masks_t m;
    m = '{known: 1'b1, rd: 32'hFFFF_FFFF, wr: 32'h0, lock: 32'h0, clr: 32'h0};
    case (idx)
      IxCtrl: begin
        m.rd   = 32'h7FC0_0F03;
        m.wr   = 32'h7FC0_0F03;
        m.lock = 32'h7FC0_0F00;
      end
      IxModes:     m.wr = 32'h0;
      IxConfig: begin
        m.rd = 32'hFFFF_FFF0;
        m.wr = 32'h0000_000F;
      end
      IxStatus:    m.clr = 32'hFFFF_DA00;
      IxCpuConfig: begin
        m.wr   = 32'h07FF_FFFF;
        m.lock = 32'h07FF_7FFF;
      end
      IxTimings:   m.wr = 32'h0;
      IxIrqEnable: m.wr = 32'hFFFF_FE00;
      IxDma: begin
        m.rd  = 32'h7FFF_FFFE;
        m.wr  = 32'h8000_0002;
        m.clr = 32'h0000_0001;
      end
      IxInstrModes:  m.wr = 32'h0000_07FF;
      IxInstrCs:     m.wr = 32'h0000_0003;
      IxInstrLen:    m.wr = 32'h0000_FFFF;
      IxInstrParams: m.wr = 32'h0000_1FFF;
      IxTxLo:        m.wr = 32'hFFFF_FFFF;
      IxTxHi:        m.wr = 32'h0000_000F;
      IxRxLo:        m.wr = 32'hFFFF_FFFF;
      IxRxHi:        m.wr = 32'h0000_000F;
      IxAxiId:       m.wr = 32'h0000_FFFF;
      IxVersion:     m.wr = 32'h0;
      IxCpuTimings: begin
        m.wr   = 32'h07FF_FF00;
        m.lock = 32'h07FF_FF00;
      end
      default:     m = '0;
    endcase
    return m;
  endfunction

  function automatic logic [31:0] reg_reset(logic [IdxW-1:0] idx);
    logic [31:0] v;
    case (idx)
      IxVersion:    v = 32'h1012_0343;
      IxStatus:     v = 32'h0000_0046;
      IxCpuConfig:  v = 32'h0011_0303;
      IxTimings:    v = 32'h0070_4111;
      IxCpuTimings: v = 32'h0070_4100;
      default:      v = 32'h0;
    endcase
    return v;
  endfunction

endpackage

/* hdl/sdcr_req_if.sv */
// Request channel interface: one register access per beat.
`timescale 1ns / 1ps
interface sdcr_req_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [7:0]  reg_offset;
  logic [31:0] write_data;

  modport source(output valid, output req_type, output reg_offset, output write_data,
                 input ready);
  modport sink(input valid, input req_type, input reg_offset, input write_data,
               output ready);
endinterface

/* hdl/sdcr_rsp_if.sv */
// Response channel interface: one access result per beat.
`timescale 1ns / 1ps
interface sdcr_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_level;
  logic [3:0]  chip_select_lines;
  logic        xfer_start;
  logic        xfer_send;
  logic        xfer_receive;
  logic [16:0] xfer_length;
  logic [35:0] xfer_source_addr;
  logic [35:0] xfer_dest_addr;
  logic [1:0]  xfer_target;

  modport source(output valid, output read_data, output irq_level, output chip_select_lines,
                 output xfer_start, output xfer_send, output xfer_receive, output xfer_length,
                 output xfer_source_addr, output xfer_dest_addr, output xfer_target,
                 input ready);
  modport sink(input valid, input read_data, input irq_level, input chip_select_lines,
               input xfer_start, input xfer_send, input xfer_receive, input xfer_length,
               input xfer_source_addr, input xfer_dest_addr, input xfer_target,
               output ready);
endinterface

/* hdl/sdcr_regfile.sv */
// Register array, interrupt and chip select state with the access and launch logic.
`timescale 1ns / 1ps
module sdcr_regfile
  import sdcr_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  access_t acc_i,
  output result_t res_o
);

  localparam logic [3:0] TgtMask = 4'((1 << TargetCount) - 1);

  logic [31:0]     regs_q [RegCount];
  logic [31:0]     regs_d [RegCount];
  logic            irq_q, irq_d;
  logic [3:0]      sel_q, sel_d;

  logic [5:0]      word_idx;
  logic [IdxW-1:0] idx;
  masks_t          m;
  logic            known;
  logic [31:0]     v;
  logic [31:0]     wmask;
  logic [31:0]     cleared;
  logic [31:0]     wword;
  logic            wr_en;
  logic            launch;
  logic [31:0]     params;
  logic [1:0]      target;
  logic [LenW-1:0] len;
  logic [31:0]     stat_set;

  assign word_idx = acc_i.offset[7:2];
  assign idx      = word_idx[IdxW-1:0];
  assign m        = reg_masks(idx);
  assign known    = (word_idx[5] == 1'b0) && m.known;
  assign v        = acc_i.wdata << {acc_i.offset[1:0], 3'b000};
  assign wr_en    = acc_i.valid && acc_i.is_write && known;
  assign cleared  = regs_q[idx] & ~(v & m.clr);
  assign wmask    = regs_q[IxCpuConfig][UnlockBit] ? m.wr : (m.wr & ~m.lock);
  assign wword    = (cleared & ~wmask) | (v & wmask);
  assign launch   = wr_en && (idx == IxDma) && v[DmaGoBit];

  assign params = regs_q[IxInstrParams];
  assign target = regs_q[IxInstrCs][1:0];

  always_comb begin
    len = {1'b0, regs_q[IxInstrLen][15:0]};
    if ((len == '0) || (len > LenW'(MaxTransfer))) begin
      len = LenW'(MaxTransfer);
    end
  end

  always_comb begin
    stat_set = 32'h0;
    stat_set[StFinishBit] = 1'b1;
    stat_set[StDoneBit]   = params[DoneBit] || (regs_q[IxIrqEnable] != 32'h0);
  end

  always_comb begin
    regs_d = regs_q;
    irq_d  = irq_q;
    sel_d  = sel_q;
    if (wr_en) begin
      regs_d[idx] = wword;
      if (idx == IxConfig) begin
        sel_d = sel_q | (v[3:0] & TgtMask);
      end else if (idx == IxStatus) begin
        if (v[StDoneBit] || v[StFinishBit]) begin
          irq_d = 1'b0;
        end
      end
    end
    if (launch) begin
      regs_d[IxStatus] = regs_q[IxStatus] | stat_set;
      if (int'(target) < TargetCount) begin
        sel_d[target] = !params[HoldBit];
      end
      if (regs_q[IxIrqEnable] != 32'h0) begin
        irq_d = 1'b1;
      end
    end
  end

  always_comb begin
    res_o = '0;
    if (!acc_i.is_write && (acc_i.offset[1:0] == 2'b00) && known) begin
      res_o.read_data = regs_q[idx] & m.rd;
    end
    res_o.irq_level         = irq_d;
    res_o.chip_select_lines = sel_d;
    if (launch) begin
      res_o.xfer_start       = 1'b1;
      res_o.xfer_send        = params[SendBit];
      res_o.xfer_receive     = params[RecvBit];
      res_o.xfer_length      = len;
      res_o.xfer_source_addr = {regs_q[IxTxHi][3:0], regs_q[IxTxLo]};
      res_o.xfer_dest_addr   = {regs_q[IxRxHi][3:0], regs_q[IxRxLo]};
      res_o.xfer_target      = target;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < RegCount; i++) begin
        regs_q[i] <= reg_reset(IdxW'(i));
      end
      irq_q <= 1'b0;
      sel_q <= 4'hF;
    end else if (acc_i.valid) begin
      regs_q <= regs_d;
      irq_q  <= irq_d;
      sel_q  <= sel_d;
    end
  end

endmodule

/* hdl/spi_dma_controller_registers.sv */
// Top level of the SPI controller register block with the DMA command launcher.
// Each request beat is one 32-bit register read or write and yields exactly one response
// beat. A beat passes an input register and then a result register before its response
// appears; one beat is accepted in every cycle while responses are taken. A write of DMA
// bit 31 returns the transfer command in the same response beat as the write itself.
`timescale 1ns / 1ps
module spi_dma_controller_registers
  import sdcr_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  sdcr_req_if.sink   req_i,
  sdcr_rsp_if.source rsp_o
);

  logic    s1_valid_q;
  access_t s1_q;
  access_t acc;
  logic    out_valid_q;
  result_t out_q;
  result_t res;
  logic    adv;

  assign adv         = s1_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !s1_valid_q || adv;

  always_comb begin
    acc       = s1_q;
    acc.valid = adv;
  end

  sdcr_regfile u_regfile (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .acc_i (acc),
    .res_o (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_i.ready) begin
        s1_valid_q <= req_i.valid;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      s1_q.valid    <= 1'b1;
      s1_q.is_write <= req_i.req_type;
      s1_q.offset   <= req_i.reg_offset;
      s1_q.wdata    <= req_i.write_data;
    end
    if (adv) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid             = out_valid_q;
  assign rsp_o.read_data         = out_q.read_data;
  assign rsp_o.irq_level         = out_q.irq_level;
  assign rsp_o.chip_select_lines = out_q.chip_select_lines;
  assign rsp_o.xfer_start        = out_q.xfer_start;
  assign rsp_o.xfer_send         = out_q.xfer_send;
  assign rsp_o.xfer_receive      = out_q.xfer_receive;
  assign rsp_o.xfer_length       = out_q.xfer_length;
  assign rsp_o.xfer_source_addr  = out_q.xfer_source_addr;
  assign rsp_o.xfer_dest_addr    = out_q.xfer_dest_addr;
  assign rsp_o.xfer_target       = out_q.xfer_target;

endmodule

/* hdl/sdcr_checker.sv */
// Port-level checker for the register block and its bind to the top level.
`timescale 1ns / 1ps
`include "spi_dma_controller_registers_defines.svh"
module sdcr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] read_data_i,
  input logic        xfer_start_i,
  input logic        xfer_send_i,
  input logic        xfer_receive_i,
  input logic [16:0] xfer_length_i,
  input logic [35:0] xfer_source_addr_i,
  input logic [35:0] xfer_dest_addr_i,
  input logic [1:0]  xfer_target_i
);

  logic idle_beat;
  logic launch_beat;
  logic rsp_stall;
  logic cmd_zero;

  assign idle_beat   = rsp_valid_i && !xfer_start_i;
  assign launch_beat = rsp_valid_i && xfer_start_i;
  assign rsp_stall   = rsp_valid_i && !rsp_ready_i;
  assign cmd_zero    = !xfer_send_i && !xfer_receive_i && (xfer_length_i == 17'd0) &&
                       (xfer_source_addr_i == 36'd0) && (xfer_dest_addr_i == 36'd0) &&
                       (xfer_target_i == 2'd0);

  // A beat without a launch carries an all-zero command.
  `SDCR_ASSERT_IMP(a_idle_cmd_zero, idle_beat, cmd_zero, "Command set without a launch.")

  // A launched command never carries a zero length.
  `SDCR_ASSERT_IMP(a_len_nonzero, launch_beat, xfer_length_i != 17'd0, "Zero launch length.")

  // Launches come from writes, which return no read data.
  `SDCR_ASSERT_IMP(a_launch_no_rdata, launch_beat, read_data_i == 32'd0, "Launch with read data.")

  // A stalled response beat stays and holds its data.
  `SDCR_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid_i && $stable(read_data_i), "Stalled beat changed.")

endmodule

bind spi_dma_controller_registers sdcr_checker u_sdcr_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .rsp_valid_i       (rsp_o.valid),
  .rsp_ready_i       (rsp_o.ready),
  .read_data_i       (rsp_o.read_data),
  .xfer_start_i      (rsp_o.xfer_start),
  .xfer_send_i       (rsp_o.xfer_send),
  .xfer_receive_i    (rsp_o.xfer_receive),
  .xfer_length_i     (rsp_o.xfer_length),
  .xfer_source_addr_i(rsp_o.xfer_source_addr),
  .xfer_dest_addr_i  (rsp_o.xfer_dest_addr),
  .xfer_target_i     (rsp_o.xfer_target)
);
